/* rtl/vvf_pkg.sv */
// Shared types and constants for the vortex velocity field point core.
// Used by the square-root cell, the divider cell and the top level.
`default_nettype none

package vvf_pkg;

   // Field widths.
   localparam int COORD_W  = 9;
   localparam int RADIUS_W = 16;
   localparam int VEL_W    = 16;
   localparam int R2_W     = 19;
   localparam int RQ_W     = 18;

   // Cell chain lengths: one root bit and one quotient bit per cell.
   localparam int SQ_CELLS  = 18;
   localparam int DIV_CELLS = 17;

   localparam int SQ_REM_W  = 35;
   localparam int DIV_REM_W = 43;
   localparam int DIV_DEN_W = 26;

   // Sine polynomial coefficients, Q28.
   localparam logic [30:0] SIN_C1 = 31'd843314857;
   localparam logic [30:0] SIN_C3 = 31'd1387197337;
   localparam logic [30:0] SIN_C5 = 31'd684554447;
   localparam logic [30:0] SIN_C7 = 31'd160863847;
   localparam logic [30:0] SIN_C9 = 31'd22050868;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_CENTER_X     = 2'd0,
      REG_CENTER_Y     = 2'd1,
      REG_SWIRL_RADIUS = 2'd2,
      REG_SPEED_GAIN   = 2'd3
   } reg_index_type;

   // Word handed along the square-root chain.
   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [RQ_W-1:0]     root;
   } sqrt_word_type;

   // Word handed along a divider chain.
   typedef struct packed {
      logic [DIV_REM_W-1:0] rem;
      logic [DIV_DEN_W-1:0] den;
      logic [DIV_CELLS-1:0] quo;
   } div_word_type;

   // Per-item side information carried beside the cell chains.
   typedef struct packed {
      logic [COORD_W-1:0] adr;
      logic [COORD_W-1:0] adc;
      logic               dr_neg;
      logic               dc_neg;
      logic               dr_nz;
      logic [R2_W-1:0]    r2;
      logic               in_radius;
      logic               zero;
      logic [RQ_W-1:0]    rq;
      logic [15:0]        u;
      logic [14:0]        u2;
      logic [30:0]        acc;
      logic [16:0]        sq;
      logic [32:0]        ms;
   } item_type;

   // One result word.
   typedef struct packed {
      logic [VEL_W-1:0] vel_x;
      logic [VEL_W-1:0] vel_y;
      logic             in_radius;
   } result_type;

endpackage

`default_nettype wire

/* rtl/vvf_sqrt_cell.sv */
// One cell of the bit-serial integer square-root chain: settles one root bit.
// Depends on vvf_pkg for the word type.
`default_nettype none

module vvf_sqrt_cell
   import vvf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [4:0]    bit_pos,
   input  wire sqrt_word_type word_i,
   output sqrt_word_type      word_o
);

   sqrt_word_type word_ff;
   sqrt_word_type word_in;
   logic [SQ_REM_W:0] trial;
   logic              take;

   // Adding this bit to the root grows its square by 2*root*2^b + 2^(2b).
   always_comb begin
      trial = ((SQ_REM_W+1)'(word_i.root) << (6'(bit_pos) + 6'd1))
            + ((SQ_REM_W+1)'(1) << {bit_pos, 1'b0});
      take  = {1'b0, word_i.rem} >= trial;
      word_in = word_i;
      if (take) begin
         word_in.rem  = word_i.rem - trial[SQ_REM_W-1:0];
         word_in.root = word_i.root | (RQ_W'(1) << bit_pos);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;

endmodule

`default_nettype wire

/* rtl/vvf_div_cell.sv */
// One cell of a restoring divider chain: settles one quotient bit.
// Depends on vvf_pkg for the word type.
`default_nettype none

module vvf_div_cell
   import vvf_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [4:0]   bit_pos,
   input  wire div_word_type word_i,
   output div_word_type      word_o
);

   div_word_type         word_ff;
   div_word_type         word_in;
   logic [DIV_REM_W-1:0] den_sh;

   // Subtract the divisor at this bit weight when it fits.
   always_comb begin
      den_sh  = DIV_REM_W'(word_i.den) << bit_pos;
      word_in = word_i;
      if (word_i.rem >= den_sh) begin
         word_in.rem = word_i.rem - den_sh;
         word_in.quo = word_i.quo | (DIV_CELLS'(1) << bit_pos);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;

endmodule

`default_nettype wire

/* rtl/vortex_velocity_field_point_core.sv */
// Top level of the vortex velocity field point core.
// Depends on vvf_pkg, vvf_sqrt_cell and vvf_div_cell.
//
// Usage:
//   Request channel (req_valid, req_stall, req_row, req_col) carries one grid
//   point per word. Response channel (rsp_valid, rsp_stall, rsp_vel_x,
//   rsp_vel_y, rsp_inside_res) returns one velocity word per point, in order.
//   A word moves on a rising edge where valid is high and stall is low.
//   The configuration channel (csr_valid, csr_ready, csr_index, csr_data)
//   writes centre, radius and gain; csr_ready is always high. Write it only
//   while no point is in flight.
//   Throughput is one point per cycle while req_stall is low. The response word
//   passes through 65 register stages after the edge that accepts it, set by the
//   18-cell square-root chain, the 17-cell phase divider, the sine polynomial
//   stages and the 17-cell velocity dividers.
//   When the receiver stalls, the pipeline advances once more into a skid
//   register and then raises req_stall until the skid register drains.
//   Reset clears all valid flags and the configuration registers to zero.
`default_nettype none

module vortex_velocity_field_point_core
   import vvf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [COORD_W-1:0]   req_row,
   input  wire logic [COORD_W-1:0]   req_col,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic signed [VEL_W-1:0]   rsp_vel_x,
   output logic signed [VEL_W-1:0]   rsp_vel_y,
   output logic                      rsp_inside_res,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [1:0]           csr_index,
   input  wire logic [15:0]          csr_data
);

   localparam logic [30:0] HORNER_COEF [4] = '{SIN_C7, SIN_C5, SIN_C3, SIN_C1};

   // Configuration registers and values derived from them.
   logic [COORD_W-1:0]    cx_ff, cy_ff;
   logic [RADIUS_W-1:0]   rad_ff;
   logic [15:0]           gain_ff;
   logic [31:0]           rr_ff;
   logic [15:0]           mag_ff;
   logic                  sneg_ff;

   // Pipeline control.
   logic en;
   logic out_ready;

   // Front stages.
   item_type a_ff, a_in, b_ff, b_in;
   logic     va_ff, vb_ff;
   logic [COORD_W:0] dr, dc;

   // Square-root chain.
   sqrt_word_type sq_w_i [SQ_CELLS];
   sqrt_word_type sq_w_o [SQ_CELLS];
   item_type      sq_sb_ff [SQ_CELLS];
   logic          sq_v_ff  [SQ_CELLS];
   item_type      sq_entry;

   // Phase divider chain.
   div_word_type ph_w_i [DIV_CELLS];
   div_word_type ph_w_o [DIV_CELLS];
   item_type     ph_sb_ff [DIV_CELLS];
   logic         ph_v_ff  [DIV_CELLS];
   item_type     ph_entry;

   // Sine polynomial stages.
   item_type p0_ff, p0_in, p1_ff, p1_in, p6_ff, p6_in;
   logic     vp0_ff, vp1_ff, vp6_ff;
   item_type hs_ff [4];
   item_type hs_in [4];
   logic     vhs_ff [4];
   logic [16:0] ph_clamp;
   logic [45:0] h_prod [4];
   logic [46:0] s_prod;
   logic [18:0] s_val;

   // Velocity stages.
   item_type v1_ff, v1_in, v2_ff;
   logic     vv1_ff, vv2_ff;
   logic [DIV_REM_W-1:0] nx_ff, ny_ff, nx_in, ny_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   div_word_type dx_w_i [DIV_CELLS];
   div_word_type dx_w_o [DIV_CELLS];
   div_word_type dy_w_i [DIV_CELLS];
   div_word_type dy_w_o [DIV_CELLS];
   item_type     dv_sb_ff [DIV_CELLS];
   logic         dv_v_ff  [DIV_CELLS];

   // Final stage, output register and skid register.
   result_type fo_ff, fo_in, rsp_ff, skid_ff;
   logic       vfo_ff, rsp_valid_ff, skid_valid_ff;
   logic [DIV_CELLS-1:0] qx, qy;
   logic       neg_x, neg_y;

   // The whole pipeline moves unless the skid register is holding a word.
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff   <= '0;
         cy_ff   <= '0;
         rad_ff  <= '0;
         gain_ff <= '0;
         rr_ff   <= '0;
         mag_ff  <= '0;
         sneg_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (reg_index_type'(csr_index))
               REG_CENTER_X:     cx_ff   <= csr_data[COORD_W-1:0];
               REG_CENTER_Y:     cy_ff   <= csr_data[COORD_W-1:0];
               REG_SWIRL_RADIUS: rad_ff  <= csr_data;
               REG_SPEED_GAIN:   gain_ff <= csr_data;
               default:          ;
            endcase
         end
         rr_ff   <= 32'(rad_ff) * 32'(rad_ff);
         mag_ff  <= gain_ff[15] ? 16'(16'd0 - gain_ff) : gain_ff;
         sneg_ff <= gain_ff[15];
      end
   end

   // Offsets from the centre, and the squared distance.
   always_comb begin
      dr = {1'b0, req_row} - {1'b0, cy_ff};
      dc = {1'b0, req_col} - {1'b0, cx_ff};
      a_in        = '0;
      a_in.dr_neg = dr[COORD_W];
      a_in.dc_neg = dc[COORD_W];
      a_in.adr    = dr[COORD_W] ? COORD_W'(-dr) : dr[COORD_W-1:0];
      a_in.adc    = dc[COORD_W] ? COORD_W'(-dc) : dc[COORD_W-1:0];
      a_in.dr_nz  = req_row != cy_ff;
      b_in        = a_ff;
      b_in.r2     = R2_W'(a_ff.adr) * R2_W'(a_ff.adr)
                  + R2_W'(a_ff.adc) * R2_W'(a_ff.adc);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   // Radius test beside the root chain entry.
   always_comb begin
      sq_entry           = b_ff;
      sq_entry.in_radius = 32'({b_ff.r2, 8'b0}) <= rr_ff;
      sq_entry.zero      = (b_ff.r2 == '0) || (rad_ff == '0);
      sq_w_i[0]          = '{rem: {b_ff.r2, 16'b0}, root: '0};
   end

   // Square-root cells, most significant root bit first.
   for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
      if (k > 0) begin : g_link
         assign sq_w_i[k] = sq_w_o[k-1];
      end
      vvf_sqrt_cell u_cell (
         .clock   (clock),
         .en      (en),
         .bit_pos (5'(SQ_CELLS - 1 - k)),
         .word_i  (sq_w_i[k]),
         .word_o  (sq_w_o[k])
      );
   end

   // Phase r/R in Q16: divide the Q8 distance shifted by twelve by the radius.
   always_comb begin
      ph_entry    = sq_sb_ff[SQ_CELLS-1];
      ph_entry.rq = sq_w_o[SQ_CELLS-1].root;
      ph_w_i[0]   = '{rem: DIV_REM_W'({sq_w_o[SQ_CELLS-1].root, 12'b0}),
                      den: DIV_DEN_W'(rad_ff), quo: '0};
   end

   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_phase
      if (k > 0) begin : g_link
         assign ph_w_i[k] = ph_w_o[k-1];
      end
      vvf_div_cell u_cell (
         .clock   (clock),
         .en      (en),
         .bit_pos (5'(DIV_CELLS - 1 - k)),
         .word_i  (ph_w_i[k]),
         .word_o  (ph_w_o[k])
      );
   end

   // Sine of pi times the phase by an odd polynomial in Horner form.
   always_comb begin
      ph_clamp = (ph_w_o[DIV_CELLS-1].quo > 17'd65536) ? 17'd65536
                                                       : ph_w_o[DIV_CELLS-1].quo;
      p0_in    = ph_sb_ff[DIV_CELLS-1];
      p0_in.u  = (ph_clamp <= 17'd32768) ? 16'(ph_clamp) : 16'(17'd65536 - ph_clamp);
      p1_in    = p0_ff;
      p1_in.u2 = 15'((32'(p0_ff.u) * 32'(p0_ff.u)) >> 16);
      p1_in.acc = SIN_C9;
      for (int i = 0; i < 4; i++) begin
         hs_in[i]     = (i == 0) ? p1_ff : hs_ff[i-1];
         h_prod[i]    = 46'(hs_in[i].acc) * 46'(hs_in[i].u2);
         hs_in[i].acc = HORNER_COEF[i] - 31'(h_prod[i][45:16]);
      end
      s_prod   = 47'(hs_ff[3].acc) * 47'(hs_ff[3].u) + (47'd1 << 27);
      s_val    = s_prod[46:28];
      p6_in    = hs_ff[3];
      p6_in.sq = (s_val > 19'd65536) ? 17'd65536 : 17'(s_val);
   end

   // Velocity numerators, with half the divisor added for rounding.
   always_comb begin
      v1_in    = p6_ff;
      v1_in.ms = 33'(mag_ff) * 33'(p6_ff.sq);
      den_in   = {v1_ff.rq, 8'b0};
      nx_in    = DIV_REM_W'(v1_ff.ms) * DIV_REM_W'(v1_ff.adc)
               + DIV_REM_W'({v1_ff.rq, 7'b0});
      ny_in    = DIV_REM_W'(v1_ff.ms) * DIV_REM_W'(v1_ff.adr)
               + DIV_REM_W'({v1_ff.rq, 7'b0});
      dx_w_i[0] = '{rem: nx_ff, den: den_ff, quo: '0};
      dy_w_i[0] = '{rem: ny_ff, den: den_ff, quo: '0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         for (int i = 0; i < 4; i++) begin
            hs_ff[i] <= hs_in[i];
         end
         p6_ff  <= p6_in;
         v1_ff  <= v1_in;
         v2_ff  <= v1_ff;
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         den_ff <= den_in;
      end
   end

   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_vel
      if (k > 0) begin : g_link
         assign dx_w_i[k] = dx_w_o[k-1];
         assign dy_w_i[k] = dy_w_o[k-1];
      end
      vvf_div_cell u_cell_x (
         .clock   (clock),
         .en      (en),
         .bit_pos (5'(DIV_CELLS - 1 - k)),
         .word_i  (dx_w_i[k]),
         .word_o  (dx_w_o[k])
      );
      vvf_div_cell u_cell_y (
         .clock   (clock),
         .en      (en),
         .bit_pos (5'(DIV_CELLS - 1 - k)),
         .word_i  (dy_w_i[k]),
         .word_o  (dy_w_o[k])
      );
   end

   // Side information that travels beside the cell chains.
   always_ff @(posedge clock) begin
      if (en) begin
         sq_sb_ff[0] <= sq_entry;
         ph_sb_ff[0] <= ph_entry;
         dv_sb_ff[0] <= v2_ff;
         for (int k = 1; k < SQ_CELLS; k++) begin
            sq_sb_ff[k] <= sq_sb_ff[k-1];
         end
         for (int k = 1; k < DIV_CELLS; k++) begin
            ph_sb_ff[k] <= ph_sb_ff[k-1];
            dv_sb_ff[k] <= dv_sb_ff[k-1];
         end
      end
   end

   // Valid flags for every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         vb_ff  <= 1'b0;
         vp0_ff <= 1'b0;
         vp1_ff <= 1'b0;
         vp6_ff <= 1'b0;
         vv1_ff <= 1'b0;
         vv2_ff <= 1'b0;
         vfo_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            vhs_ff[i] <= 1'b0;
         end
         for (int k = 0; k < SQ_CELLS; k++) begin
            sq_v_ff[k] <= 1'b0;
         end
         for (int k = 0; k < DIV_CELLS; k++) begin
            ph_v_ff[k] <= 1'b0;
            dv_v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         va_ff      <= req_valid;
         vb_ff      <= va_ff;
         sq_v_ff[0] <= vb_ff;
         for (int k = 1; k < SQ_CELLS; k++) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
         ph_v_ff[0] <= sq_v_ff[SQ_CELLS-1];
         for (int k = 1; k < DIV_CELLS; k++) begin
            ph_v_ff[k] <= ph_v_ff[k-1];
         end
         vp0_ff    <= ph_v_ff[DIV_CELLS-1];
         vp1_ff    <= vp0_ff;
         vhs_ff[0] <= vp1_ff;
         for (int i = 1; i < 4; i++) begin
            vhs_ff[i] <= vhs_ff[i-1];
         end
         vp6_ff     <= vhs_ff[3];
         vv1_ff     <= vp6_ff;
         vv2_ff     <= vv1_ff;
         dv_v_ff[0] <= vv2_ff;
         for (int k = 1; k < DIV_CELLS; k++) begin
            dv_v_ff[k] <= dv_v_ff[k-1];
         end
         vfo_ff <= dv_v_ff[DIV_CELLS-1];
      end
   end

   // Sign, saturation and the outside or centre cases.
   always_comb begin
      qx    = dx_w_o[DIV_CELLS-1].quo;
      qy    = dy_w_o[DIV_CELLS-1].quo;
      neg_x = sneg_ff != dv_sb_ff[DIV_CELLS-1].dc_neg;
      neg_y = (sneg_ff == dv_sb_ff[DIV_CELLS-1].dr_neg) && dv_sb_ff[DIV_CELLS-1].dr_nz;
      fo_in.in_radius = dv_sb_ff[DIV_CELLS-1].in_radius;
      if (neg_x) begin
         fo_in.vel_x = (qx > 17'd32768) ? 16'h8000 : 16'(17'd0 - qx);
      end else begin
         fo_in.vel_x = (qx > 17'd32767) ? 16'h7FFF : qx[15:0];
      end
      if (neg_y) begin
         fo_in.vel_y = (qy > 17'd32768) ? 16'h8000 : 16'(17'd0 - qy);
      end else begin
         fo_in.vel_y = (qy > 17'd32767) ? 16'h7FFF : qy[15:0];
      end
      if (!dv_sb_ff[DIV_CELLS-1].in_radius || dv_sb_ff[DIV_CELLS-1].zero) begin
         fo_in.vel_x = '0;
         fo_in.vel_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fo_ff <= fo_in;
      end
   end

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff  <= skid_valid_ff || vfo_ff;
         skid_valid_ff <= 1'b0;
      end else if (vfo_ff && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         rsp_ff <= skid_valid_ff ? skid_ff : fo_ff;
      end else if (!skid_valid_ff) begin
         skid_ff <= fo_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vel_x      = rsp_ff.vel_x;
   assign rsp_vel_y      = rsp_ff.vel_y;
   assign rsp_inside_res = rsp_ff.in_radius;

`ifndef NO_ASSERTIONS
   // The skid register only fills behind a held output word.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full without an output word");

   // A full skid register drains as soon as the receiver takes the output.
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> !skid_valid_ff)
      else $error("skid register did not drain");

   // Points outside the radius carry zero velocity.
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inside_res |-> (rsp_vel_x == '0) && (rsp_vel_y == '0))
      else $error("nonzero velocity outside the radius");
`endif

endmodule

`default_nettype wire

/* bench/vortex_velocity_field_point_core_tb.sv */
// Self-checking bench for the vortex velocity field point core.
// Depends on vvf_pkg and the vortex_velocity_field_point_core top level.
`default_nettype none

module vortex_velocity_field_point_core_tb;
   import vvf_pkg::*;

   localparam int LATENCY    = 65;
   localparam int WATCH_MAX  = 20000;
   localparam int RAND_ITEMS = 930;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } point_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [COORD_W-1:0] req_row;
   logic [COORD_W-1:0] req_col;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [VEL_W-1:0] rsp_vel_x;
   logic signed [VEL_W-1:0] rsp_vel_y;
   logic rsp_inside_res;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [15:0] csr_data;

   // Shadow copy of the configuration registers.
   logic [8:0] cfg_cx, cfg_cy;
   logic [15:0] cfg_radius;
   logic signed [15:0] cfg_gain;

   point_type pending_points[$];
   result_type expected_vel[$];
   int send_idle_pct, stall_pct;
   int quiet_cycles;
   bit failed;
   bit req_taken;

   vortex_velocity_field_point_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_row(req_row), .req_col(req_col),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_vel_x(rsp_vel_x), .rsp_vel_y(rsp_vel_y),
      .rsp_inside_res(rsp_inside_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bit-serial integer square root, floor.
   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Sine of pi*ph/65536 in Q16 by the odd polynomial.
   function automatic longint unsigned sine_q16(longint unsigned ph);
      longint unsigned u, u2, acc, s;
      if (ph > 65536) ph = 65536;
      u = (ph <= 32768) ? ph : 65536 - ph;
      u2 = (u * u) >> 16;
      acc = 22050868;
      acc = 160863847 - ((acc * u2) >> 16);
      acc = 684554447 - ((acc * u2) >> 16);
      acc = 1387197337 - ((acc * u2) >> 16);
      acc = 843314857 - ((acc * u2) >> 16);
      s = (acc * u + (64'd1 << 27)) >> 28;
      return (s > 65536) ? 65536 : s;
   endfunction

   // Scaled, rounded and saturated velocity component.
   function automatic logic [15:0] scaled_component(longint unsigned mag, bit neg,
         longint unsigned sq, longint unsigned absd, longint unsigned rq);
      longint unsigned den, q;
      den = 256 * rq;
      q = (mag * sq * absd + den / 2) / den;
      if (neg) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
      return (q > 32767) ? 16'h7fff : 16'(q);
   endfunction

   // Velocity expected at one grid point under the current settings.
   function automatic result_type swirl_velocity(point_type p);
      result_type res;
      int dr, dc;
      longint unsigned adr, adc, r2, rad, rq, ph, sq, mag;
      bit gneg;
      res = '0;
      dr = int'(p.row) - int'(cfg_cy);
      dc = int'(p.col) - int'(cfg_cx);
      adr = (dr < 0) ? -dr : dr;
      adc = (dc < 0) ? -dc : dc;
      r2 = adr * adr + adc * adc;
      rad = cfg_radius;
      if (256 * r2 > rad * rad) return res;
      res.in_radius = 1'b1;
      if (r2 == 0 || rad == 0) return res;
      rq = floor_root(r2 << 16);
      ph = (rq * 4096) / rad;
      sq = sine_q16(ph);
      gneg = cfg_gain < 0;
      mag = gneg ? -longint'(cfg_gain) : longint'(cfg_gain);
      res.vel_x = scaled_component(mag, gneg != (dc < 0), sq, adc, rq);
      res.vel_y = scaled_component(mag, (gneg == (dr < 0)) && dr != 0, sq, adr, rq);
      return res;
   endfunction

   // Configuration write: waits for ready, then updates the shadow copy.
   task automatic write_reg(reg_index_type idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_CENTER_X:     cfg_cx = val[8:0];
         REG_CENTER_Y:     cfg_cy = val[8:0];
         REG_SWIRL_RADIUS: cfg_radius = val;
         REG_SPEED_GAIN:   cfg_gain = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_swirl(logic [8:0] cx, logic [8:0] cy, logic [15:0] rad,
         logic [15:0] gain);
      write_reg(REG_CENTER_X, {7'h0, cx});
      write_reg(REG_CENTER_Y, {7'h0, cy});
      write_reg(REG_SWIRL_RADIUS, rad);
      write_reg(REG_SPEED_GAIN, gain);
   endtask

   task automatic push_point(int r, int c);
      point_type p;
      p.row = r[8:0];
      p.col = c[8:0];
      pending_points.push_back(p);
   endtask

   // Waits until every queued point is sent and answered, then lets the pipe settle.
   task automatic drain_all();
      while (pending_points.size() != 0 || expected_vel.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // Records whether the offered point was taken at this rising edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
   end

   // Driver: offers the front point at the falling edge, holding it until taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_taken || !req_valid) begin
         if (req_taken) begin
            void'(pending_points.pop_front());
         end
         if (pending_points.size() > 0 &&
             $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_row <= pending_points[0].row;
            req_col <= pending_points[0].col;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99, 0) < stall_pct);
   end

   // Monitor: predicts on each accepted point and checks each accepted word.
   always @(posedge clock) begin
      result_type got, want;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_vel.push_back(swirl_velocity({req_row, req_col}));
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got = {rsp_vel_x, rsp_vel_y, rsp_inside_res};
            if (expected_vel.size() == 0) begin
               $display("%0t: unexpected word %h", $time, got);
               failed = 1'b1;
            end else begin
               want = expected_vel.pop_front();
               if (got.vel_x !== want.vel_x) begin
                  $display("%0t: vel_x expected %0d actual %0d", $time,
                     $signed(want.vel_x), $signed(got.vel_x));
                  failed = 1'b1;
               end
               if (got.vel_y !== want.vel_y) begin
                  $display("%0t: vel_y expected %0d actual %0d", $time,
                     $signed(want.vel_y), $signed(got.vel_y));
                  failed = 1'b1;
               end
               if (got.in_radius !== want.in_radius) begin
                  $display("%0t: inside_res expected %0b actual %0b", $time,
                     want.in_radius, got.in_radius);
                  failed = 1'b1;
               end
            end
         end
         quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      end
   end

   // Watchdog on cycles with no word moving.
   always @(posedge clock) begin
      if (quiet_cycles >= WATCH_MAX) begin
         $display("[vortex_velocity_field_point_core] ERROR");
         $finish;
      end
   end

   initial begin
      int phase_sel, cx, cy;
      logic [15:0] rad;
      failed = 1'b0;
      quiet_cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_row = '0;
      req_col = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_CENTER_X;
      csr_data = '0;
      cfg_cx = '0; cfg_cy = '0; cfg_radius = '0; cfg_gain = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset settings: only the centre point is inside.
      push_point(0, 0);
      push_point(0, 1);
      drain_all();

      // Directed: centre, edges, corners, full-scale gain, zero radius.
      set_swirl(9'd256, 9'd256, 16'd2048, 16'h7fff);
      push_point(256, 256);
      push_point(256, 384);
      push_point(384, 256);
      push_point(128, 256);
      push_point(256, 128);
      push_point(256, 257);
      push_point(300, 200);
      push_point(0, 0);
      push_point(511, 511);
      push_point(256, 320);
      drain_all();
      set_swirl(9'd0, 9'd511, 16'hffff, 16'h8000);
      push_point(511, 0);
      push_point(0, 0);
      push_point(511, 511);
      push_point(0, 511);
      push_point(300, 300);
      push_point(510, 1);
      drain_all();
      set_swirl(9'd100, 9'd100, 16'd0, 16'h0100);
      push_point(100, 100);
      push_point(100, 101);
      push_point(101, 100);
      drain_all();
      set_swirl(9'd10, 9'd10, 16'd16, 16'h8000);
      push_point(10, 11);
      push_point(11, 10);
      push_point(9, 10);
      drain_all();

      // Random phases under varied settings and idling patterns.
      for (int ph = 0; ph < 12; ph++) begin
         phase_sel = ph % 4;
         send_idle_pct = (phase_sel == 1 || phase_sel == 3) ? 63 : 0;
         stall_pct = (phase_sel == 2 || phase_sel == 3) ? 63 : 0;
         if (phase_sel == 3) begin
            send_idle_pct = 19;
            stall_pct = 19;
         end
         rad = (ph == 5) ? 16'hffff : (ph == 6) ? 16'd0 : 16'($urandom_range(8000, 16));
         set_swirl(9'($urandom), 9'($urandom), rad, 16'($urandom));
         for (int k = 0; k < RAND_ITEMS / 12; k++) begin
            // Mostly points near the centre so that the inside path is busy.
            if ($urandom_range(3, 0) != 0) begin
               cx = int'(cfg_cx) + $urandom_range(2 * (rad >> 4) + 2, 0)
                  - int'(rad >> 4) - 1;
               cy = int'(cfg_cy) + $urandom_range(2 * (rad >> 4) + 2, 0)
                  - int'(rad >> 4) - 1;
               if (cx < 0) cx = 0;
               if (cx > 511) cx = 511;
               if (cy < 0) cy = 0;
               if (cy > 511) cy = 511;
               push_point(cy, cx);
            end else begin
               push_point($urandom_range(511, 0), $urandom_range(511, 0));
            end
         end
         drain_all();
      end

      if (!failed) begin
         $display("[vortex_velocity_field_point_core] OK");
      end else begin
         $display("[vortex_velocity_field_point_core] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
rtl/vvf_pkg.sv
rtl/vvf_sqrt_cell.sv
rtl/vvf_div_cell.sv
rtl/vortex_velocity_field_point_core.sv
bench/vortex_velocity_field_point_core_tb.sv
